[rtl/drm_pkg.sv]
// Shared types and constants for the dirty rectangle merger.
// Used by drm_ctrl, drm_datapath and dirty_rectangle_merger_unit; no dependencies.
`default_nettype none

package drm_pkg;

   localparam int MAX_RECTS = 5;
   localparam int CNT_W     = $clog2(MAX_RECTS);   // holds 0 .. MAX_RECTS-1
   localparam int EDGE_W    = 16;
   localparam int SCREEN_W  = 15;
   localparam int CSR_IDX_W = 2;
   localparam int SPAN_W    = EDGE_W + 1;
   localparam int AREA_W    = 2 * SPAN_W;
   localparam int SUM_W     = AREA_W + 1;
   localparam int GAIN_W    = AREA_W + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      CMD_MARK  = 2'd0,
      CMD_FULL  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_EMIT  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [EDGE_W-1:0]  x_left;
      logic signed [EDGE_W-1:0]  y_top;
      logic signed [EDGE_W-1:0]  x_right;
      logic signed [EDGE_W-1:0]  y_bottom;
   } req_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0]  out_left;
      logic signed [EDGE_W-1:0]  out_top;
      logic signed [EDGE_W-1:0]  out_right;
      logic signed [EDGE_W-1:0]  out_bottom;
      logic                      rect_valid;
      logic                      final_item;
      logic [2:0]                rect_count;
      logic                      whole_screen;
   } rsp_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0]  l;
      logic signed [EDGE_W-1:0]  t;
      logic signed [EDGE_W-1:0]  r;
      logic signed [EDGE_W-1:0]  b;
   } rect_type;

   typedef enum logic [2:0] {
      COMMIT_NONE   = 3'd0,
      COMMIT_APPEND = 3'd1,
      COMMIT_FULL   = 3'd2,
      COMMIT_CLEAR  = 3'd3,
      COMMIT_MERGE  = 3'd4
   } commit_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       scan_clr;
      logic       mul_new;
      logic       mul_entry;
      logic       mul_union;
      logic       eval;
      commit_type commit;
      logic       out_none;
      logic       out_entry;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    count_full;
      logic    idx_zero;
      logic    idx_last;
      logic    contained;
      logic    best_valid;
      logic    out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/drm_datapath.sv]
// Rectangle table, screen size registers, shared area multiplier, merge scan and result register.
// Depends on drm_pkg; driven by drm_ctrl through dp_cmd_type.
`default_nettype none

module drm_datapath
   import drm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire req_type               req_data,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SCREEN_W-1:0]   csr_wdata,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire dp_cmd_type            dp_cmd,
   output dp_status_type              dp_status
);

   rect_type                   entries [MAX_RECTS];
   req_type                    req_ff;
   logic [SCREEN_W-1:0]        width_ff,  width_in;
   logic [SCREEN_W-1:0]        height_ff, height_in;
   logic [CNT_W-1:0]           count_ff,  count_in;
   logic [CNT_W-1:0]           idx_ff,    idx_in;

   logic signed [AREA_W-1:0]   area_n_ff, area_o_ff, area_u_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   rect_type                   union_ff, cand_ff, best_union_ff;
   logic [CNT_W-1:0]           cand_idx_ff, best_idx_ff;
   logic signed [GAIN_W-1:0]   best_gain_ff;
   logic                       best_valid_ff, best_valid_in;
   logic                       contained_ff,  contained_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff;

   rect_type                   new_rect, entry, union_rect, full_rect;
   logic                       contain_hit;
   logic signed [SPAN_W-1:0]   mul_a, mul_b;
   logic signed [AREA_W-1:0]   mul_prod;
   logic signed [GAIN_W-1:0]   gain;
   logic                       better;
   logic                       whole;
   logic                       out_free;
   logic                       idx_last;

   assign new_rect = '{l: req_ff.x_left, t: req_ff.y_top,
                       r: req_ff.x_right, b: req_ff.y_bottom};
   assign full_rect = '{l: '0, t: '0,
                        r: {1'b0, width_ff}, b: {1'b0, height_ff}};
   assign entry = entries[idx_ff];

   // Bounding box of the scanned entry and the new rectangle
   always_comb begin
      union_rect.l = (entry.l < new_rect.l) ? entry.l : new_rect.l;
      union_rect.t = (entry.t < new_rect.t) ? entry.t : new_rect.t;
      union_rect.r = (entry.r > new_rect.r) ? entry.r : new_rect.r;
      union_rect.b = (entry.b > new_rect.b) ? entry.b : new_rect.b;
   end

   assign contain_hit = (entry.l <= new_rect.l) && (entry.t <= new_rect.t) &&
                        (entry.r >= new_rect.r) && (entry.b >= new_rect.b);

   // One shared multiplier: width times height of the selected rectangle
   always_comb begin
      priority if (dp_cmd.mul_new) begin
         mul_a = SPAN_W'(new_rect.r) - SPAN_W'(new_rect.l);
         mul_b = SPAN_W'(new_rect.b) - SPAN_W'(new_rect.t);
      end else if (dp_cmd.mul_entry) begin
         mul_a = SPAN_W'(entry.r) - SPAN_W'(entry.l);
         mul_b = SPAN_W'(entry.b) - SPAN_W'(entry.t);
      end else begin
         mul_a = SPAN_W'(union_ff.r) - SPAN_W'(union_ff.l);
         mul_b = SPAN_W'(union_ff.b) - SPAN_W'(union_ff.t);
      end
      mul_prod = mul_a * mul_b;
   end

   assign gain   = GAIN_W'(sum_ff) - GAIN_W'(area_u_ff);
   assign better = (gain > GAIN_W'(0)) && (!best_valid_ff || (gain > best_gain_ff));

   assign idx_last = (idx_ff == (count_ff - CNT_W'(1)));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign whole    = (count_ff == CNT_W'(1)) &&
                     (entries[0].r == {1'b0, width_ff}) &&
                     (entries[0].b == {1'b0, height_ff});

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         if (csr_index == CSR_SCREEN_WIDTH) begin
            width_in = csr_wdata;
         end else if (csr_index == CSR_SCREEN_HEIGHT) begin
            height_in = csr_wdata;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      unique case (dp_cmd.commit)
         COMMIT_APPEND: count_in = count_ff + CNT_W'(1);
         COMMIT_FULL:   count_in = CNT_W'(1);
         COMMIT_CLEAR:  count_in = '0;
         default:       count_in = count_ff;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (dp_cmd.idx_clr) begin
         idx_in = '0;
      end else if (dp_cmd.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      contained_in  = contained_ff;
      best_valid_in = best_valid_ff;
      if (dp_cmd.scan_clr) begin
         contained_in  = 1'b0;
         best_valid_in = 1'b0;
      end else begin
         if (dp_cmd.mul_entry && contain_hit) begin
            contained_in = 1'b1;
         end
         if (dp_cmd.eval && better) begin
            best_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.out_none || dp_cmd.out_entry) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= '0;
         height_ff     <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         contained_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         contained_ff  <= contained_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and table storage, no reset
   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         req_ff <= req_data;
      end
      if (dp_cmd.mul_new) begin
         area_n_ff <= mul_prod;
      end
      if (dp_cmd.mul_entry) begin
         area_o_ff <= mul_prod;
         union_ff  <= union_rect;
      end
      if (dp_cmd.mul_union) begin
         area_u_ff   <= mul_prod;
         sum_ff      <= SUM_W'(area_o_ff) + SUM_W'(area_n_ff);
         cand_ff     <= union_ff;
         cand_idx_ff <= idx_ff;
      end
      if (dp_cmd.eval && better) begin
         best_gain_ff  <= gain;
         best_idx_ff   <= cand_idx_ff;
         best_union_ff <= cand_ff;
      end
      unique case (dp_cmd.commit)
         COMMIT_APPEND: entries[count_ff]    <= new_rect;
         COMMIT_FULL:   entries[0]           <= full_rect;
         COMMIT_MERGE:  entries[best_idx_ff] <= best_union_ff;
         default: ;
      endcase
      if (dp_cmd.out_none) begin
         rsp_data_ff.out_left   <= '0;
         rsp_data_ff.out_top    <= '0;
         rsp_data_ff.out_right  <= '0;
         rsp_data_ff.out_bottom <= '0;
         rsp_data_ff.rect_valid <= 1'b0;
         rsp_data_ff.final_item <= 1'b1;
      end else if (dp_cmd.out_entry) begin
         rsp_data_ff.out_left   <= entry.l;
         rsp_data_ff.out_top    <= entry.t;
         rsp_data_ff.out_right  <= entry.r;
         rsp_data_ff.out_bottom <= entry.b;
         rsp_data_ff.rect_valid <= 1'b1;
         rsp_data_ff.final_item <= idx_last;
      end
      if (dp_cmd.out_none || dp_cmd.out_entry) begin
         rsp_data_ff.rect_count   <= 3'(count_ff);
         rsp_data_ff.whole_screen <= whole;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign dp_status.cmd        = req_ff.cmd;
   assign dp_status.count_zero = (count_ff == '0);
   assign dp_status.count_full = (count_ff >= CNT_W'(MAX_RECTS - 1));
   assign dp_status.idx_zero   = (idx_ff == '0);
   assign dp_status.idx_last   = idx_last;
   assign dp_status.contained  = contained_ff;
   assign dp_status.best_valid = best_valid_ff;
   assign dp_status.out_free   = out_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS - 1))
      else $error("rectangle count beyond table size");

   a_merge_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit == COMMIT_MERGE) |=> (count_ff == $past(count_ff)))
      else $error("merge changed the rectangle count");

endmodule

`default_nettype wire

[rtl/drm_ctrl.sv]
// Controller state machine: sequences the mark scan, commits and result beats.
// Depends on drm_pkg; talks to drm_datapath through dp_cmd_type and dp_status_type.
`default_nettype none

module drm_ctrl
   import drm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output dp_cmd_type         dp_cmd,
   input  wire dp_status_type dp_status
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_DECIDE  = 9'b000000010,
      ST_AREA_N  = 9'b000000100,
      ST_AREA_O  = 9'b000001000,
      ST_AREA_U  = 9'b000010000,
      ST_EVAL    = 9'b000100000,
      ST_UPDATE  = 9'b001000000,
      ST_RESPOND = 9'b010000000,
      ST_EMIT    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      dp_cmd.commit = COMMIT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (dp_status.cmd)
               CMD_MARK: begin
                  if (dp_status.count_zero) begin
                     dp_cmd.commit = COMMIT_APPEND;
                     state_in = ST_RESPOND;
                  end else if (dp_status.count_full) begin
                     dp_cmd.commit = COMMIT_FULL;
                     state_in = ST_RESPOND;
                  end else begin
                     state_in = ST_AREA_N;
                  end
               end
               CMD_FULL: begin
                  dp_cmd.commit = COMMIT_FULL;
                  state_in = ST_RESPOND;
               end
               CMD_CLEAR: begin
                  dp_cmd.commit = COMMIT_CLEAR;
                  state_in = ST_RESPOND;
               end
               CMD_EMIT: begin
                  dp_cmd.idx_clr = 1'b1;
                  state_in = dp_status.count_zero ? ST_RESPOND : ST_EMIT;
               end
            endcase
         end
         ST_AREA_N: begin
            dp_cmd.mul_new  = 1'b1;
            dp_cmd.idx_clr  = 1'b1;
            dp_cmd.scan_clr = 1'b1;
            state_in = ST_AREA_O;
         end
         ST_AREA_O: begin
            // score the previous entry while this one is read
            dp_cmd.mul_entry = 1'b1;
            dp_cmd.eval      = !dp_status.idx_zero;
            state_in = ST_AREA_U;
         end
         ST_AREA_U: begin
            dp_cmd.mul_union = 1'b1;
            if (dp_status.idx_last) begin
               state_in = ST_EVAL;
            end else begin
               dp_cmd.idx_inc = 1'b1;
               state_in = ST_AREA_O;
            end
         end
         ST_EVAL: begin
            dp_cmd.eval = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (dp_status.contained) begin
               dp_cmd.commit = COMMIT_NONE;
            end else if (dp_status.best_valid) begin
               dp_cmd.commit = COMMIT_MERGE;
            end else begin
               dp_cmd.commit = COMMIT_APPEND;
            end
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (dp_status.out_free) begin
               dp_cmd.out_none = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (dp_status.out_free) begin
               dp_cmd.out_entry = 1'b1;
               if (dp_status.idx_last) begin
                  state_in = ST_IDLE;
               end else begin
                  dp_cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.out_none || dp_cmd.out_entry) |-> dp_status.out_free)
      else $error("result beat loaded over an untaken beat");

   a_single_commit: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.commit != COMMIT_NONE) |=> (dp_cmd.commit == COMMIT_NONE))
      else $error("table committed twice in a row");

endmodule

`default_nettype wire

[rtl/dirty_rectangle_merger_unit.sv]
// Top level of the dirty rectangle merger: damage rectangle table with merge scan.
// Depends on drm_pkg, drm_ctrl and drm_datapath.
//
//   channel | ports                                       | direction
//   req     | req_valid, req_ready, req_data              | in,  one command beat
//   rsp     | rsp_valid, rsp_ready, rsp_data              | out, one or more result beats
//   csr     | csr_valid, csr_ready, csr_index, csr_wdata  | in,  screen size writes
//
// Clear, full-screen and the trivial marks pass via decide to respond, which loads the
// result. A mark scan computes the new area, then an entry and a union area per stored
// entry, then evaluates and updates; the single shared multiplier computes one area per
// cycle, two per entry. Emit loads its first result beat in the emit state after decide,
// then one beat per cycle per stored rectangle while rsp is not stalled.
// Result beats sit in an output register; a stalled rsp holds the sequencer.
// Reset clears the count and screen size; csr writes are always taken.
`default_nettype none

module dirty_rectangle_merger_unit
   import drm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SCREEN_W-1:0]   csr_wdata
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   assign csr_ready = 1'b1;

   drm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   drm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

endmodule

`default_nettype wire
